FILE: hw/rtl/twrle_pkg.sv
// ----------------------------------------------------------------------------
// twrle_pkg
// Types and constants shared by the tile word run-length encoder.
// ----------------------------------------------------------------------------
package twrle_pkg;

    // Fixed field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 8;

    // Longest run, counted in extra words after the head
    localparam logic [COUNT_W-1:0] MAX_RUN = 8'd255;

    // Step between words of a rising run
    localparam logic [WORD_W-1:0] RISE_STEP = 32'h0000_0100;

    // Most result items that one request can cause
    localparam int unsigned MAX_PUSH = 3;

    // Segment run mode, also the flag placed in bits 31:30
    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_EQUAL = 2'd1,
        RUN_RISE  = 2'd2
    } t_run_mode;

    // Result item kind
    typedef enum logic {
        KIND_TILE  = 1'b0,
        KIND_COUNT = 1'b1
    } t_item_kind;

    typedef struct packed {
        t_item_kind        item_kind;
        logic [WORD_W-1:0] item_data;
        logic              end_of_output;
    } t_item;

    // Group of result items written to the queue in one cycle
    typedef struct packed {
        logic [1:0]           n;
        t_item [MAX_PUSH-1:0] items;
    } t_push;

endpackage

FILE: hw/rtl/twrle_in_if.sv
// ----------------------------------------------------------------------------
// twrle_in_if
// Tile word request channel: valid/ready with word and end-of-layer mark.
// ----------------------------------------------------------------------------
interface twrle_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] tile_word;
    logic        end_of_layer;

    modport source (output valid, output tile_word, output end_of_layer, input ready);
    modport sink   (input valid, input tile_word, input end_of_layer, output ready);
endinterface

FILE: hw/rtl/twrle_out_if.sv
// ----------------------------------------------------------------------------
// twrle_out_if
// Result channel: valid/ready with item kind, data and end-of-output mark.
// ----------------------------------------------------------------------------
interface twrle_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [31:0] item_data;
    logic        end_of_output;

    modport source (output valid, output item_kind, output item_data,
                    output end_of_output, input ready);
    modport sink   (input valid, input item_kind, input item_data,
                    input end_of_output, output ready);
endinterface

FILE: hw/rtl/twrle_cfg_if.sv
// ----------------------------------------------------------------------------
// twrle_cfg_if
// Configuration write channel for the compress enable register.
// ----------------------------------------------------------------------------
interface twrle_cfg_if;
    logic valid;
    logic ready;
    logic compress_enable;

    modport source (output valid, output compress_enable, input ready);
    modport sink   (input valid, input compress_enable, output ready);
endinterface

FILE: hw/rtl/twrle_core.sv
// ----------------------------------------------------------------------------
// twrle_core
// Input register, segment state and per-word encode logic. Produces up to
// three result items per processed request as one push to the queue.
// ----------------------------------------------------------------------------
module twrle_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    twrle_in_if.sink             i_in,
    twrle_cfg_if.sink            i_cfg,
    input  logic                 i_room,
    output twrle_pkg::t_push     o_push
);

    // Input register
    logic                          r_in_valid;
    logic [twrle_pkg::WORD_W-1:0]  r_in_word;
    logic                          r_in_last;

    // Configuration
    logic                          r_enable;

    // Segment state
    logic [twrle_pkg::WORD_W-1:0]  r_head, n_head;
    logic [twrle_pkg::WORD_W-1:0]  r_prev, n_prev;
    twrle_pkg::t_run_mode          r_mode, n_mode;
    logic [twrle_pkg::COUNT_W-1:0] r_cnt,  n_cnt;
    logic                          r_hv,   n_hv;

    logic                          proc;
    twrle_pkg::t_item [twrle_pkg::MAX_PUSH-1:0] slots;
    logic [1:0]                    k;
    logic [twrle_pkg::WORD_W-1:0]  rise;

    // Process the held request when the queue has room for a full push
    assign proc        = r_in_valid && i_room;
    assign i_in.ready  = !r_in_valid || i_room;
    assign i_cfg.ready = 1'b1;
    assign rise        = r_prev + twrle_pkg::RISE_STEP;

    // Encode one word: flush, start or extend the pending segment
    always_comb begin
        n_head = r_head;
        n_prev = r_prev;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_hv   = r_hv;
        slots  = '0;
        k      = 2'd0;

        if (!r_enable) begin
            // Pass-through: flush pending segment, then the word itself
            if (n_hv) begin
                slots[k] = '{twrle_pkg::KIND_TILE, n_head | {n_mode, 30'd0}, 1'b0};
                k = k + 2'd1;
                if (n_mode != twrle_pkg::RUN_NONE) begin
                    slots[k] = '{twrle_pkg::KIND_COUNT,
                                 {{(twrle_pkg::WORD_W-twrle_pkg::COUNT_W){1'b0}}, n_cnt},
                                 1'b0};
                    k = k + 2'd1;
                end
            end
            n_hv     = 1'b0;
            n_mode   = twrle_pkg::RUN_NONE;
            n_cnt    = '0;
            slots[k] = '{twrle_pkg::KIND_TILE, r_in_word, 1'b0};
            k = k + 2'd1;
        end else if (!r_hv) begin
            n_head = r_in_word;
            n_prev = r_in_word;
            n_mode = twrle_pkg::RUN_NONE;
            n_cnt  = '0;
            n_hv   = 1'b1;
        end else if (r_mode == twrle_pkg::RUN_NONE && r_in_word == r_prev) begin
            n_mode = twrle_pkg::RUN_EQUAL;
            n_cnt  = 8'd1;
        end else if (r_mode == twrle_pkg::RUN_NONE && r_in_word == rise) begin
            n_mode = twrle_pkg::RUN_RISE;
            n_cnt  = 8'd1;
            n_prev = r_in_word;
        end else if (r_mode == twrle_pkg::RUN_EQUAL && r_in_word == r_prev
                     && r_cnt < twrle_pkg::MAX_RUN) begin
            n_cnt = r_cnt + 8'd1;
        end else if (r_mode == twrle_pkg::RUN_RISE && r_in_word == rise
                     && r_cnt < twrle_pkg::MAX_RUN) begin
            n_cnt  = r_cnt + 8'd1;
            n_prev = r_in_word;
        end else begin
            // Segment broken or full: flush it and start a new one
            slots[k] = '{twrle_pkg::KIND_TILE, r_head | {r_mode, 30'd0}, 1'b0};
            k = k + 2'd1;
            if (r_mode != twrle_pkg::RUN_NONE) begin
                slots[k] = '{twrle_pkg::KIND_COUNT,
                             {{(twrle_pkg::WORD_W-twrle_pkg::COUNT_W){1'b0}}, r_cnt},
                             1'b0};
                k = k + 2'd1;
            end
            n_head = r_in_word;
            n_prev = r_in_word;
            n_mode = twrle_pkg::RUN_NONE;
            n_cnt  = '0;
            n_hv   = 1'b1;
        end

        // End of layer: flush what is pending and mark the last item
        if (r_in_last) begin
            if (n_hv) begin
                slots[k] = '{twrle_pkg::KIND_TILE, n_head | {n_mode, 30'd0}, 1'b0};
                k = k + 2'd1;
                if (n_mode != twrle_pkg::RUN_NONE) begin
                    slots[k] = '{twrle_pkg::KIND_COUNT,
                                 {{(twrle_pkg::WORD_W-twrle_pkg::COUNT_W){1'b0}}, n_cnt},
                                 1'b0};
                    k = k + 2'd1;
                end
            end
            n_hv   = 1'b0;
            n_mode = twrle_pkg::RUN_NONE;
            n_cnt  = '0;
            if (k != 2'd0) begin
                slots[k - 2'd1].end_of_output = 1'b1;
            end
        end
    end

    assign o_push.n     = proc ? k : 2'd0;
    assign o_push.items = slots;

    // Hold input register, configuration and segment state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_enable   <= 1'b1;
            r_head     <= '0;
            r_prev     <= '0;
            r_mode     <= twrle_pkg::RUN_NONE;
            r_cnt      <= '0;
            r_hv       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_enable <= i_cfg.compress_enable;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_head <= n_head;
                r_prev <= n_prev;
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_hv   <= n_hv;
            end
        end
    end

    // Capture request payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.tile_word;
            r_in_last <= i_in.end_of_layer;
        end
    end

endmodule

FILE: hw/rtl/twrle_queue.sv
// ----------------------------------------------------------------------------
// twrle_queue
// Result queue: takes up to three items per cycle, sends one per cycle while o_out is ready.
// ----------------------------------------------------------------------------
module twrle_queue #(
    parameter int unsigned DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  twrle_pkg::t_push i_push,
    output logic             o_room,
    twrle_out_if.source      o_out
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    twrle_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    r_wr_ptr;
    logic [CW-1:0]    r_count;
    logic             pop;

    // Step a pointer forward by up to three slots, wrapping at DEPTH
    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] base,
                                              input logic [1:0]    step);
        logic [PW+1:0] sum;
        sum = {2'b00, base} + {{PW{1'b0}}, step};
        if (sum >= (PW+2)'(DEPTH)) begin
            sum = sum - (PW+2)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign pop    = (r_count != '0) && o_out.ready;
    assign o_room = r_count <= CW'(DEPTH - twrle_pkg::MAX_PUSH);

    // Drive head of queue
    assign o_out.valid         = r_count != '0;
    assign o_out.item_kind     = r_mem[r_rd_ptr].item_kind;
    assign o_out.item_data     = r_mem[r_rd_ptr].item_data;
    assign o_out.end_of_output = r_mem[r_rd_ptr].end_of_output;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= ptr_add(r_wr_ptr, i_push.n);
            if (pop) begin
                r_rd_ptr <= ptr_add(r_rd_ptr, 2'd1);
            end
            r_count <= r_count + CW'(i_push.n) - CW'(pop);
        end
    end

    // Write pushed items in order
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < twrle_pkg::MAX_PUSH; i++) begin
            if (2'(i) < i_push.n) begin
                r_mem[ptr_add(r_wr_ptr, 2'(i))] <= i_push.items[i];
            end
        end
    end

endmodule

FILE: hw/rtl/tile_word_run_length_encoder.sv
// ----------------------------------------------------------------------------
// tile_word_run_length_encoder
// Run-length coder for 32-bit tile words with equal and rising runs.
//
//   channel  | dir | handshake     | payload
//   i_in     | in  | valid/ready   | tile_word[31:0], end_of_layer
//   o_out    | out | valid/ready   | item_kind, item_data[31:0], end_of_output
//   i_cfg    | in  | valid/ready   | compress_enable (ready always high)
//
// One request enters per cycle; a request is encoded from the input register
// once taken, and its items (zero to three) land in the result queue together.
// Results leave at one per cycle while o_out is ready, so the output rate sets
// throughput when runs are short. A held request waits, and input stalls, while the
// queue lacks room for three items.
// Reset is synchronous, active low: queue empty, no pending segment,
// compression enabled.
// ----------------------------------------------------------------------------
module tile_word_run_length_encoder #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twrle_in_if.sink    i_in,
    twrle_cfg_if.sink   i_cfg,
    twrle_out_if.source o_out
);

    twrle_pkg::t_push w_push;
    logic             w_room;

    twrle_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    twrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // Never push without room for a full group
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.n != 2'd0) |-> w_room)
        else $error("push without queue room");

    // A group always opens with a tile word
    a_push_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.n != 2'd0) |-> (w_push.items[0].item_kind == twrle_pkg::KIND_TILE))
        else $error("group opens with a count item");

    // End mark only on the last item of a group
    a_push_eoo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.n == 2'd3 && !w_push.items[0].end_of_output
            && !w_push.items[1].end_of_output)
        || (w_push.n == 2'd2 && !w_push.items[0].end_of_output)
        || w_push.n == 2'd1 || w_push.n == 2'd0)
        else $error("end mark before last item");

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule
